// ===== rtl/dglt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dglt_pkg
// Shared types and constants of the directional group lock table.
// ----------------------------------------------------------------------------
package dglt_pkg;

	localparam int DEF_NUM_GROUPS = 16;
	localparam int DEF_NUM_OWNERS = 16;

	localparam int DIR_W   = 2;
	localparam int CAP_W   = 8;
	localparam int EXP_W   = 32;
	localparam int ENTRY_W = EXP_W + CAP_W + DIR_W;

	localparam int IN_DATA_W  = 80;
	localparam int OUT_DATA_W = 48;

	typedef enum logic [1:0] {
		CMD_RESERVE = 2'd0,
		CMD_RELEASE = 2'd1,
		CMD_REL_ALL = 2'd2,
		CMD_FIND    = 2'd3
	} cmd_t;

	// Controller to datapath.
	typedef struct packed {
		logic load;
		logic step;
		logic fin;
	} ctrl_t;

	// Datapath to controller.
	typedef struct packed {
		cmd_t cmd;
		logic bad;
		logic out_free;
	} stat_t;

endpackage
`default_nettype wire

// ===== rtl/directional_group_lock_table_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// directional_group_lock_table_core
// Table of directional group locks with reserve, release and blocking query.
// ----------------------------------------------------------------------------
// Each word on the slave side is one command. Reserve, release and find-blocking
// walk the NUM_OWNERS entries of one group, one entry per cycle through the
// single read port of the entry memory. The result word shows up on m_tvalid
// after the start, scan, drain and finish states, and the slave side reopens in
// the same cycle that the result word shows up, so commands never overlap.
// Release-all walks every entry of the table, so its result comes only
// after all NUM_GROUPS * NUM_OWNERS entries have been read. A command with an
// out-of-range group or owner skips the walk and returns an all-zero word from
// the finish state. A held-off result stalls the block in its final state, and a
// new command is taken once the previous result sits in the output register.
module directional_group_lock_table_core #(
	parameter int NUM_GROUPS = dglt_pkg::DEF_NUM_GROUPS,
	parameter int NUM_OWNERS = dglt_pkg::DEF_NUM_OWNERS
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	// group[3:0], owner[7:4], direction[9:8], capacity[17:10], ttl[41:18],
	// now[73:42], zero fill above
	input  wire logic [dglt_pkg::IN_DATA_W-1:0]      s_tdata,
	// command[1:0]
	input  wire logic [1:0]                          s_tuser,
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	// granted[0], found[1], blocking_owner[5:2], blocking_direction[7:6],
	// blocking_capacity[15:8], blocking_expiry[47:16]
	output logic [dglt_pkg::OUT_DATA_W-1:0]          m_tdata
);

	localparam int TOTAL = NUM_GROUPS * NUM_OWNERS;
	localparam int IW    = $clog2(TOTAL);
	localparam int OW    = $clog2(NUM_OWNERS);

	dglt_pkg::ctrl_t ctrl;
	dglt_pkg::stat_t stat;
	logic [IW-1:0]   idx, base_idx;
	logic [OW-1:0]   opos;

	dglt_ctrl #(
		.NUM_GROUPS(NUM_GROUPS),
		.NUM_OWNERS(NUM_OWNERS)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.stat    (stat),
		.base_idx(base_idx),
		.ctrl    (ctrl),
		.idx     (idx),
		.opos    (opos)
	);

	dglt_dpath #(
		.NUM_GROUPS(NUM_GROUPS),
		.NUM_OWNERS(NUM_OWNERS)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (s_tdata),
		.in_cmd   (s_tuser),
		.out_ready(m_tready),
		.out_valid(m_tvalid),
		.out_data (m_tdata),
		.ctrl     (ctrl),
		.idx      (idx),
		.opos     (opos),
		.stat     (stat),
		.base_idx (base_idx)
	);

	// A result never reports both a grant and a blocking holder.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
		else $error("granted and found both set");

	// Without a blocking holder the holder fields read as zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tdata[1]) |-> (m_tdata[47:2] == 46'd0))
		else $error("holder fields set without a holder");

	// One command at a time: an accepted word closes the slave side.
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("second word accepted while a command is in progress");

endmodule
`default_nettype wire

// ===== rtl/dglt_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dglt_ram
// Generic memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module dglt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
`default_nettype wire

// ===== rtl/dglt_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dglt_ctrl
// Sequencer that walks the table entries a command touches.
// ----------------------------------------------------------------------------
module dglt_ctrl #(
	parameter int NUM_GROUPS = dglt_pkg::DEF_NUM_GROUPS,
	parameter int NUM_OWNERS = dglt_pkg::DEF_NUM_OWNERS,
	localparam int TOTAL = NUM_GROUPS * NUM_OWNERS,
	localparam int IW    = $clog2(TOTAL),
	localparam int OW    = $clog2(NUM_OWNERS)
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire dglt_pkg::stat_t stat,
	input  wire logic [IW-1:0]   base_idx,
	output dglt_pkg::ctrl_t      ctrl,
	output logic [IW-1:0]        idx,
	output logic [OW-1:0]        opos
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_START,
		S_SCAN,
		S_DRAIN,
		S_FINISH
	} state_t;

	state_t        state_q;
	logic [IW-1:0] idx_q;
	logic [OW-1:0] oc_q;
	logic          last_step;

	assign last_step = (stat.cmd == dglt_pkg::CMD_REL_ALL) ? (idx_q == IW'(TOTAL - 1))
	                                                      : (oc_q == OW'(NUM_OWNERS - 1));

	assign in_ready  = (state_q == S_IDLE);
	assign ctrl.load = in_valid && in_ready;
	assign ctrl.step = (state_q == S_SCAN);
	assign ctrl.fin  = (state_q == S_FINISH) && stat.out_free;
	assign idx       = idx_q;
	assign opos      = oc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
			oc_q    <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (ctrl.load) begin
						state_q <= S_START;
					end
				end
				S_START: begin
					oc_q  <= '0;
					idx_q <= (stat.cmd == dglt_pkg::CMD_REL_ALL) ? '0 : base_idx;
					state_q <= stat.bad ? S_FINISH : S_SCAN;
				end
				S_SCAN: begin
					idx_q <= idx_q + IW'(1);
					oc_q  <= (oc_q == OW'(NUM_OWNERS - 1)) ? '0 : oc_q + OW'(1);
					if (last_step) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					if (stat.out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== rtl/dglt_dpath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dglt_dpath
// Entry storage, per-entry evaluation, accumulators and result register.
// ----------------------------------------------------------------------------
module dglt_dpath #(
	parameter int NUM_GROUPS = dglt_pkg::DEF_NUM_GROUPS,
	parameter int NUM_OWNERS = dglt_pkg::DEF_NUM_OWNERS,
	localparam int TOTAL = NUM_GROUPS * NUM_OWNERS,
	localparam int IW    = $clog2(TOTAL),
	localparam int OW    = $clog2(NUM_OWNERS),
	localparam int CW    = $clog2(NUM_OWNERS) + 1
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic [dglt_pkg::IN_DATA_W-1:0]      in_data,
	input  wire logic [1:0]                          in_cmd,
	input  wire logic                                out_ready,
	output logic                                     out_valid,
	output logic [dglt_pkg::OUT_DATA_W-1:0]          out_data,
	input  wire dglt_pkg::ctrl_t                     ctrl,
	input  wire logic [IW-1:0]                       idx,
	input  wire logic [OW-1:0]                       opos,
	output dglt_pkg::stat_t                          stat,
	output logic [IW-1:0]                            base_idx
);

	dglt_pkg::cmd_t cmd_q;
	logic [3:0]  group_q, owner_q;
	logic [1:0]  dir_q;
	logic [7:0]  cap_q;
	logic [23:0] ttl_q;
	logic [31:0] now_q;

	logic [TOTAL-1:0] live_q;
	logic             step_s1;
	logic [IW-1:0]    idx_s1;
	logic [OW-1:0]    oc_s1;

	logic [dglt_pkg::ENTRY_W-1:0] rd_data, wr_data;
	logic [1:0]  e_dir;
	logic [7:0]  e_cap;
	logic [31:0] e_exp;

	logic          blocked_q, hit_q, last_v_q;
	logic [CW-1:0] same_q;
	logic [3:0]    hit_own_q, last_own_q;
	logic [1:0]    hit_dir_q, last_dir_q;
	logic [7:0]    hit_cap_q, last_cap_q;
	logic [31:0]   hit_exp_q, last_exp_q;

	logic          out_valid_q;
	logic [dglt_pkg::OUT_DATA_W-1:0] out_q;

	logic          bad, live, expired, is_own, active, conflict, purge, drop_own;
	logic          cap_full, grant, find_last, found;
	logic [IW-1:0] own_idx;
	logic [32:0]   sum;
	logic [31:0]   new_exp;

	assign bad      = (32'(group_q) >= NUM_GROUPS) || (32'(owner_q) >= NUM_OWNERS);
	assign base_idx = IW'(32'(group_q) * NUM_OWNERS);
	assign own_idx  = IW'(32'(group_q) * NUM_OWNERS + 32'(owner_q));

	assign stat.cmd      = cmd_q;
	assign stat.bad      = bad;
	assign stat.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			cmd_q   <= dglt_pkg::cmd_t'(in_cmd);
			group_q <= in_data[3:0];
			owner_q <= in_data[7:4];
			// The unused pattern 2'b10 counts as minus one.
			dir_q   <= (in_data[9:8] == 2'b10) ? 2'b11 : in_data[9:8];
			cap_q   <= (in_data[17:10] == 8'd0) ? 8'd1 : in_data[17:10];
			ttl_q   <= in_data[41:18];
			now_q   <= in_data[73:42];
		end
	end

	assign sum     = 33'(now_q) + 33'(ttl_q);
	assign new_exp = (ttl_q == 24'd0) ? 32'd0 : (sum[32] ? 32'hFFFF_FFFF : sum[31:0]);
	assign wr_data = {new_exp, cap_q, dir_q};

	dglt_ram #(
		.WIDTH(dglt_pkg::ENTRY_W),
		.DEPTH(TOTAL)
	) u_ram (
		.clk    (clk),
		.wr_en  (ctrl.fin && grant),
		.wr_addr(own_idx),
		.wr_data(wr_data),
		.rd_en  (ctrl.step),
		.rd_addr(idx),
		.rd_data(rd_data)
	);

	assign e_dir = rd_data[1:0];
	assign e_cap = rd_data[9:2];
	assign e_exp = rd_data[41:10];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_s1 <= 1'b0;
		end else begin
			step_s1 <= ctrl.step;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= idx;
		oc_s1  <= opos;
	end

	assign live     = live_q[idx_s1];
	assign expired  = (e_exp != 32'd0) && (now_q >= e_exp);
	assign is_own   = 8'(oc_s1) == 8'(owner_q);
	assign active   = live && !expired && !is_own;
	assign conflict = (dir_q == 2'b00) || (e_dir == 2'b00) || (e_dir != dir_q);
	assign purge    = (cmd_q != dglt_pkg::CMD_FIND) && live && expired;
	assign drop_own = ((cmd_q == dglt_pkg::CMD_RELEASE) || (cmd_q == dglt_pkg::CMD_REL_ALL))
	                  && is_own;

	assign cap_full  = 16'(same_q) >= 16'(cap_q);
	assign grant     = (cmd_q == dglt_pkg::CMD_RESERVE) && !bad && !blocked_q && !cap_full;
	assign find_last = (cmd_q == dglt_pkg::CMD_FIND) && !bad && !hit_q && (dir_q != 2'b00)
	                   && cap_full && last_v_q;
	assign found     = ((cmd_q == dglt_pkg::CMD_FIND) && !bad && hit_q) || find_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q <= '0;
		end else if (step_s1 && (purge || drop_own)) begin
			live_q[idx_s1] <= 1'b0;
		end else if (ctrl.fin && grant) begin
			live_q[own_idx] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blocked_q <= 1'b0;
			hit_q     <= 1'b0;
			last_v_q  <= 1'b0;
			same_q    <= '0;
		end else if (ctrl.load) begin
			blocked_q <= 1'b0;
			hit_q     <= 1'b0;
			last_v_q  <= 1'b0;
			same_q    <= '0;
		end else if (step_s1 && active) begin
			if (cmd_q == dglt_pkg::CMD_RESERVE) begin
				if (conflict) begin
					blocked_q <= 1'b1;
				end else if (!blocked_q) begin
					same_q <= same_q + CW'(1);
				end
			end else if (cmd_q == dglt_pkg::CMD_FIND && !hit_q) begin
				if (conflict) begin
					hit_q <= 1'b1;
				end else begin
					same_q   <= same_q + CW'(1);
					last_v_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step_s1 && active && cmd_q == dglt_pkg::CMD_FIND && !hit_q) begin
			if (conflict) begin
				hit_own_q <= 4'(oc_s1);
				hit_dir_q <= e_dir;
				hit_cap_q <= e_cap;
				hit_exp_q <= e_exp;
			end else begin
				last_own_q <= 4'(oc_s1);
				last_dir_q <= e_dir;
				last_cap_q <= e_cap;
				last_exp_q <= e_exp;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.fin) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.fin) begin
			if (!found) begin
				out_q <= {46'd0, 1'b0, grant};
			end else if (find_last) begin
				out_q <= {last_exp_q, last_cap_q, last_dir_q, last_own_q, 1'b1, 1'b0};
			end else begin
				out_q <= {hit_exp_q, hit_cap_q, hit_dir_q, hit_own_q, 1'b1, 1'b0};
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
`default_nettype wire
